// File: rtl/fepd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-end packet deframer package
// Shared constants, codes and record types of the deframer.
// ----------------------------------------------------------------------------
package fepd_pkg;

  localparam int PACKET_BYTES = 1024;
  localparam int CHIPS        = 6;
  localparam int CHANNELS     = 36;
  localparam int TEMP_WORDS   = 16;

  localparam int BLOCK_WORDS  = 2 * CHANNELS + 2;
  localparam int HEAD_WORDS   = 4;
  localparam int MIN_PACKET   = 198;
  localparam int EMPTY_PACKET = 12;
  localparam int TAIL_WORDS   = 9;

  localparam int ADDR_W  = $clog2(PACKET_BYTES);
  localparam int WIDX_W  = ADDR_W - 1;
  localparam int BC_W    = $clog2(PACKET_BYTES + 2);
  localparam int W_W     = BC_W - 1;
  localparam int BLK_W   = $clog2(PACKET_BYTES / (2 * BLOCK_WORDS) + 2);
  localparam int CHIP_IW = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int POS_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] EVENT_HEAD  = 32'hfbeefbee;
  localparam logic [31:0] LAYER_HEAD  = 32'hfa5afa5a;
  localparam logic [31:0] PACKET_TAIL = 32'hfeeefeee;
  localparam logic [31:0] EVENT_TAIL  = 32'hfeddfedd;
  localparam logic [15:0] MARK_TEMP_END   = 16'hf002;
  localparam logic [15:0] MARK_TEMP_START = 16'hf001;
  localparam logic [4:0]  LAST_LAYER  = 5'd31;

  typedef enum logic [3:0] {
    KIND_GOOD       = 4'd0,
    KIND_EMPTY      = 4'd1,
    KIND_SMALL      = 4'd2,
    KIND_BAD_LAYER  = 4'd3,
    KIND_ODD        = 4'd4,
    KIND_TEMP_BAD   = 4'd5,
    KIND_DATA_BAD   = 4'd6,
    KIND_EVENT_TIME = 4'd7,
    KIND_CHANNEL    = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    PH_HUNT_EVENT,
    PH_HUNT_LAYER,
    PH_COLLECT,
    PH_FILLER,
    PH_LAYER,
    PH_TIME,
    PH_TAIL
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLS_RD,
    ST_CLS_DIV,
    ST_CLS_SCAN,
    ST_DRN_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qlink_t;

  // first member lands in the top bits, so layer sits at bit 0
  typedef struct packed {
    logic [15:0] trigger_id;
    logic [31:0] word_value;
    logic [11:0] charge_low;
    logic [11:0] charge_high;
    logic        gain_flag;
    logic        hit_flag;
    logic [15:0] bcid;
    logic [5:0]  channel;
    logic [2:0]  chip;
    logic [4:0]  layer;
  } data_t;

  localparam int DATA_W = $bits(data_t);

  typedef struct packed {
    kind_e kind;
    logic  last;
    data_t data;
  } rec_t;

endpackage

// File: rtl/fepd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer request queue
// Short FIFO between the stream input and the processing engine.
// ----------------------------------------------------------------------------
module fepd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  fepd_pkg::item_t s_item_i,
  input  logic            pop_i,
  output fepd_pkg::qlink_t head_o
);

  fepd_pkg::item_t mem_q [fepd_pkg::QUEUE_DEPTH];
  logic [fepd_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [fepd_pkg::QPTR_W:0]   cnt_q;
  logic push, pop;

  assign s_tready_o = (cnt_q != (fepd_pkg::QPTR_W+1)'(fepd_pkg::QUEUE_DEPTH));
  assign push = s_tvalid_i && s_tready_o;
  assign pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= s_item_i;
  end

endmodule

// File: rtl/fepd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer engine
// Frame tracking, packet store, packet classification and channel drain.
// ----------------------------------------------------------------------------
module fepd_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fepd_pkg::qlink_t  head_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output fepd_pkg::rec_t    m_rec_o
);

  localparam int AW = fepd_pkg::ADDR_W;
  localparam int XW = fepd_pkg::WIDX_W;

  fepd_pkg::state_e state_q, state_d;
  fepd_pkg::phase_e phase_q, phase_d;
  logic [31:0] recent_q, recent_d;
  logic [fepd_pkg::BC_W-1:0] bc_q, bc_d;
  logic [4:0]  layer_q, layer_d;
  logic [fepd_pkg::CHIPS-1:0] mask_q, mask_d;
  logic [fepd_pkg::CHIP_IW-1:0] dchip_q, dchip_d;
  logic [fepd_pkg::POS_W-1:0]   dchan_q, dchan_d;
  logic [31:0] event_q, event_d;
  logic [1:0]  tcnt_q, tcnt_d;
  logic        out_valid_q, out_valid_d;
  fepd_pkg::rec_t out_q, out_d;

  logic [XW-1:0] start_q [fepd_pkg::CHIPS];
  logic [XW-1:0] start_d [fepd_pkg::CHIPS];
  logic [2:0]  sel_q, sel_d;
  logic [1:0]  sp_q, sp_d;
  logic [7:0]  hi_q, hi_d;
  logic [31:0] cyc_q, cyc_d;
  logic [15:0] trig_q, trig_d;
  logic        ok2_q, ok2_d;
  logic [fepd_pkg::W_W-1:0] rem_q, rem_d;
  logic [fepd_pkg::BLK_W-1:0] nblk_q, nblk_d, blk_q, blk_d;
  logic [XW-1:0] base_q, base_d;
  logic        bad_q, bad_d;
  logic [13:0] hg_q, hg_d;
  logic [11:0] lg_q, lg_d;
  fepd_pkg::rec_t rec_q, rec_d;

  // packet store
  logic [7:0] mem [fepd_pkg::PACKET_BYTES];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata_q;

  logic [XW-1:0] widx;
  logic [fepd_pkg::W_W-1:0] wcnt;
  logic          word_done;
  logic [15:0]   word;

  assign wcnt      = bc_q[fepd_pkg::BC_W-1:1];
  assign word_done = (sp_q == 2'd2);
  assign word      = {hi_q, rdata_q};
  assign raddr     = {widx, (sp_q != 2'd0)};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // word index of the current read
  always_comb begin
    widx = '0;
    case (state_q)
      fepd_pkg::ST_CLS_RD: begin
        case (sel_q)
          3'd0: widx = XW'(2);
          3'd1: widx = XW'(3);
          3'd2: widx = XW'(wcnt - fepd_pkg::W_W'(fepd_pkg::TEMP_WORDS + 5));
          3'd3: widx = XW'(wcnt - fepd_pkg::W_W'(3));
          default: widx = XW'(wcnt - fepd_pkg::W_W'(fepd_pkg::TEMP_WORDS + 4));
        endcase
      end
      fepd_pkg::ST_CLS_SCAN: widx = base_q + XW'(fepd_pkg::BLOCK_WORDS - 1);
      fepd_pkg::ST_DRN_RD: begin
        case (sel_q)
          3'd0: widx = start_q[dchip_q] + XW'(dchan_q);
          3'd1: widx = start_q[dchip_q] + XW'(fepd_pkg::CHANNELS) + XW'(dchan_q);
          default: widx = start_q[dchip_q] + XW'(fepd_pkg::BLOCK_WORDS - 2);
        endcase
      end
      default: widx = '0;
    endcase
  end

  always_comb begin
    logic [31:0] rb;
    logic [7:0]  b;
    logic        cls_go;
    logic [4:0]  cls_layer;
    logic [fepd_pkg::CHIP_IW-1:0] c;
    logic [fepd_pkg::CHIPS-1:0]   rest;
    logic [15:0] idm1;
    logic        this_bad;
    logic [31:0] et;

    state_d = state_q;   phase_d = phase_q;   recent_d = recent_q;
    bc_d = bc_q;         layer_d = layer_q;   mask_d = mask_q;
    dchip_d = dchip_q;   dchan_d = dchan_q;   event_d = event_q;
    tcnt_d = tcnt_q;     start_d = start_q;   sel_d = sel_q;
    sp_d = sp_q;         hi_d = hi_q;         cyc_d = cyc_q;
    trig_d = trig_q;     ok2_d = ok2_q;       rem_d = rem_q;
    nblk_d = nblk_q;     blk_d = blk_q;       base_d = base_q;
    bad_d = bad_q;       hg_d = hg_q;         lg_d = lg_q;
    rec_d = rec_q;       out_d = out_q;
    out_valid_d = out_valid_q && !m_tready_i;
    pop_o = 1'b0;
    we = 1'b0;
    waddr = bc_q[AW-1:0];
    wdata = head_i.item.byte_value;
    b = head_i.item.byte_value;
    rb = {recent_q[23:0], b};
    cls_go = 1'b0;
    cls_layer = layer_q;
    c = '0;
    rest = '0;
    idm1 = '0;
    this_bad = 1'b0;
    et = {event_q[23:0], b};

    // two-byte read sequence: high address, low address, assemble
    if (state_q == fepd_pkg::ST_CLS_RD || state_q == fepd_pkg::ST_CLS_SCAN ||
        state_q == fepd_pkg::ST_DRN_RD) begin
      if (sp_q == 2'd1) hi_d = rdata_q;
      sp_d = word_done ? 2'd0 : sp_q + 2'd1;
    end

    case (state_q)
      fepd_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.command) begin
            if (|mask_q) begin
              for (int i = fepd_pkg::CHIPS - 1; i >= 0; i--) begin
                if (mask_q[i]) c = fepd_pkg::CHIP_IW'(i);
              end
              dchip_d = c;
              if (dchip_q != c || dchan_q >= fepd_pkg::POS_W'(fepd_pkg::CHANNELS)) begin
                dchan_d = '0;
              end
              sel_d = '0;
              sp_d = '0;
              state_d = fepd_pkg::ST_DRN_RD;
            end
          end else begin
            recent_d = rb;
            case (phase_q)
              fepd_pkg::PH_HUNT_EVENT: begin
                if (rb == fepd_pkg::EVENT_HEAD) begin
                  phase_d = fepd_pkg::PH_HUNT_LAYER;
                  recent_d = '0;
                end
              end
              fepd_pkg::PH_HUNT_LAYER: begin
                // the head bytes themselves are never read back
                if (rb == fepd_pkg::LAYER_HEAD) begin
                  bc_d = fepd_pkg::BC_W'(4);
                  mask_d = '0;
                  dchip_d = '0;
                  dchan_d = '0;
                  phase_d = fepd_pkg::PH_COLLECT;
                end
              end
              fepd_pkg::PH_COLLECT: begin
                we = (bc_q < fepd_pkg::BC_W'(fepd_pkg::PACKET_BYTES));
                if (bc_q <= fepd_pkg::BC_W'(fepd_pkg::PACKET_BYTES)) bc_d = bc_q + 1'b1;
                if (bc_d >= fepd_pkg::BC_W'(fepd_pkg::EMPTY_PACKET) &&
                    rb == fepd_pkg::PACKET_TAIL) begin
                  phase_d = fepd_pkg::PH_FILLER;
                end
              end
              fepd_pkg::PH_FILLER: phase_d = fepd_pkg::PH_LAYER;
              fepd_pkg::PH_LAYER: begin
                if (b > 8'd31) begin
                  rec_d = '0;
                  rec_d.kind = fepd_pkg::KIND_BAD_LAYER;
                  phase_d = fepd_pkg::PH_HUNT_LAYER;
                  recent_d = '0;
                  state_d = fepd_pkg::ST_EMIT;
                end else begin
                  layer_d = b[4:0];
                  if (b[4:0] == fepd_pkg::LAST_LAYER) begin
                    event_d = '0;
                    tcnt_d = '0;
                    phase_d = fepd_pkg::PH_TIME;
                  end else begin
                    cls_go = 1'b1;
                    cls_layer = b[4:0];
                    phase_d = fepd_pkg::PH_HUNT_LAYER;
                    recent_d = '0;
                  end
                end
              end
              fepd_pkg::PH_TIME: begin
                event_d = et;
                if (tcnt_q == 2'd3) begin
                  tcnt_d = '0;
                  phase_d = fepd_pkg::PH_TAIL;
                  recent_d = '0;
                  rec_d = '0;
                  rec_d.kind = fepd_pkg::KIND_EVENT_TIME;
                  rec_d.data.layer = fepd_pkg::LAST_LAYER;
                  rec_d.data.word_value = et;
                  state_d = fepd_pkg::ST_EMIT;
                end else begin
                  tcnt_d = tcnt_q + 2'd1;
                end
              end
              fepd_pkg::PH_TAIL: begin
                if (rb == fepd_pkg::EVENT_TAIL) begin
                  cls_go = 1'b1;
                  phase_d = fepd_pkg::PH_HUNT_EVENT;
                  recent_d = '0;
                end
              end
              default: begin
                phase_d = fepd_pkg::PH_HUNT_EVENT;
                recent_d = '0;
              end
            endcase
          end
        end
      end

      fepd_pkg::ST_CLS_RD: begin
        if (word_done) begin
          sel_d = sel_q + 3'd1;
          case (sel_q)
            3'd0: cyc_d[31:16] = word;
            3'd1: cyc_d[15:0] = word;
            3'd2: trig_d = word;
            3'd3: ok2_d = (word == fepd_pkg::MARK_TEMP_END);
            default: begin
              rec_d.data.word_value = cyc_q;
              rec_d.data.trigger_id = trig_q;
              if (!ok2_q && word != fepd_pkg::MARK_TEMP_START) begin
                rec_d.kind = fepd_pkg::KIND_TEMP_BAD;
                state_d = fepd_pkg::ST_EMIT;
              end else begin
                rem_d = wcnt - fepd_pkg::W_W'(fepd_pkg::TAIL_WORDS);
                nblk_d = '0;
                state_d = fepd_pkg::ST_CLS_DIV;
              end
            end
          endcase
        end
      end

      // block count by repeated subtraction, one block a cycle
      fepd_pkg::ST_CLS_DIV: begin
        if (rem_q >= fepd_pkg::W_W'(fepd_pkg::BLOCK_WORDS)) begin
          rem_d = rem_q - fepd_pkg::W_W'(fepd_pkg::BLOCK_WORDS);
          nblk_d = nblk_q + 1'b1;
        end else if (rem_q == fepd_pkg::W_W'(fepd_pkg::TEMP_WORDS)) begin
          if (nblk_q == '0) begin
            rec_d.kind = fepd_pkg::KIND_GOOD;
            state_d = fepd_pkg::ST_EMIT;
          end else begin
            base_d = XW'(fepd_pkg::HEAD_WORDS);
            blk_d = '0;
            bad_d = 1'b0;
            sp_d = '0;
            state_d = fepd_pkg::ST_CLS_SCAN;
          end
        end else begin
          rec_d.kind = fepd_pkg::KIND_DATA_BAD;
          state_d = fepd_pkg::ST_EMIT;
        end
      end

      fepd_pkg::ST_CLS_SCAN: begin
        if (word_done) begin
          idm1 = word - 16'd1;
          if (word >= 16'd1 && word <= 16'(fepd_pkg::CHIPS)) begin
            start_d[idm1[fepd_pkg::CHIP_IW-1:0]] = base_q;
            mask_d[idm1[fepd_pkg::CHIP_IW-1:0]] = 1'b1;
          end else begin
            this_bad = 1'b1;
          end
          bad_d = bad_q || this_bad;
          base_d = base_q + XW'(fepd_pkg::BLOCK_WORDS);
          blk_d = blk_q + 1'b1;
          if (blk_d == nblk_q) begin
            rec_d.kind = bad_d ? fepd_pkg::KIND_DATA_BAD : fepd_pkg::KIND_GOOD;
            state_d = fepd_pkg::ST_EMIT;
          end
        end
      end

      fepd_pkg::ST_DRN_RD: begin
        if (word_done) begin
          sel_d = sel_q + 3'd1;
          case (sel_q)
            3'd0: hg_d = word[13:0];
            3'd1: lg_d = word[11:0];
            default: begin
              rec_d = '0;
              rec_d.kind = fepd_pkg::KIND_CHANNEL;
              rec_d.data.layer = layer_q;
              rec_d.data.chip = 3'(dchip_q);
              rec_d.data.channel = 6'(fepd_pkg::CHANNELS - 1) - 6'(dchan_q);
              rec_d.data.bcid = word;
              rec_d.data.hit_flag = hg_q[12];
              rec_d.data.gain_flag = hg_q[13];
              rec_d.data.charge_high = hg_q[11:0];
              rec_d.data.charge_low = lg_q;
              rec_d.data.word_value = cyc_q;
              rec_d.data.trigger_id = trig_q;
              rest = mask_q & ~(fepd_pkg::CHIPS'(1) << dchip_q);
              if (dchan_q == fepd_pkg::POS_W'(fepd_pkg::CHANNELS - 1)) begin
                rec_d.last = (rest == '0);
                mask_d = rest;
                dchan_d = '0;
              end else begin
                dchan_d = dchan_q + 1'b1;
              end
              state_d = fepd_pkg::ST_EMIT;
            end
          endcase
        end
      end

      fepd_pkg::ST_EMIT: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_d = rec_q;
          state_d = fepd_pkg::ST_IDLE;
        end
      end

      default: state_d = fepd_pkg::ST_IDLE;
    endcase

    // packet close: length checks first, then the store reads
    if (cls_go) begin
      rec_d = '0;
      rec_d.data.layer = cls_layer;
      state_d = fepd_pkg::ST_EMIT;
      if (bc_q < fepd_pkg::BC_W'(fepd_pkg::MIN_PACKET)) begin
        rec_d.kind = (bc_q == fepd_pkg::BC_W'(fepd_pkg::EMPTY_PACKET)) ?
                     fepd_pkg::KIND_EMPTY : fepd_pkg::KIND_SMALL;
      end else if (bc_q > fepd_pkg::BC_W'(fepd_pkg::PACKET_BYTES)) begin
        rec_d.kind = fepd_pkg::KIND_DATA_BAD;
      end else if (bc_q[0]) begin
        rec_d.kind = fepd_pkg::KIND_ODD;
      end else begin
        rec_d.kind = fepd_pkg::KIND_GOOD;
        sel_d = '0;
        sp_d = '0;
        state_d = fepd_pkg::ST_CLS_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fepd_pkg::ST_IDLE;
      phase_q     <= fepd_pkg::PH_HUNT_EVENT;
      recent_q    <= '0;
      bc_q        <= '0;
      layer_q     <= '0;
      mask_q      <= '0;
      dchip_q     <= '0;
      dchan_q     <= '0;
      event_q     <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      recent_q    <= recent_d;
      bc_q        <= bc_d;
      layer_q     <= layer_d;
      mask_q      <= mask_d;
      dchip_q     <= dchip_d;
      dchan_q     <= dchan_d;
      event_q     <= event_d;
      tcnt_q      <= tcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    sel_q   <= sel_d;
    sp_q    <= sp_d;
    hi_q    <= hi_d;
    cyc_q   <= cyc_d;
    trig_q  <= trig_d;
    ok2_q   <= ok2_d;
    rem_q   <= rem_d;
    nblk_q  <= nblk_d;
    blk_q   <= blk_d;
    base_q  <= base_d;
    bad_q   <= bad_d;
    hg_q    <= hg_d;
    lg_q    <= lg_d;
    rec_q   <= rec_d;
    out_q   <= out_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_rec_o    = out_q;

endmodule

// File: rtl/front_end_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-end packet deframer
// Byte stream deframer with packet classification and channel readout.
// ----------------------------------------------------------------------------
// Requests (a stream byte or a drain command) enter a four-deep queue, so the
// input keeps taking up to four requests while a record waits on the output
// register. A stream byte is taken in the idle state. The byte-wide packet
// store has a registered read, so a 16-bit word is read high byte first,
// then low byte, then assembled. A packet close reads five words, counts
// the chip blocks, reads the ID word of each chip block and loads the output
// register; a drain request that finds a valid chip block reads the three
// words of one channel. A layer byte above 31, a short, odd or overlong
// packet and the event time record go straight to the output register.
module front_end_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_value
  input  logic [0:0]  s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // layer, chip, channel, bcid, hit_flag, gain_flag, charge_high, charge_low,
  // word_value, trigger_id
  output logic [fepd_pkg::DATA_W-1:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // last_of_packet
);

  fepd_pkg::item_t  s_item;
  fepd_pkg::qlink_t head;
  fepd_pkg::rec_t   rec;
  logic             pop;

  assign s_item.command    = s_axis_tuser_i[0];
  assign s_item.byte_value = s_axis_tdata_i;

  fepd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_item_i   (s_item),
    .pop_i      (pop),
    .head_o     (head)
  );

  fepd_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_rec_o    (rec)
  );

  assign m_axis_tdata_o = rec.data;
  assign m_axis_tuser_o = rec.kind;
  assign m_axis_tlast_o = rec.last;

endmodule

// File: rtl/fepd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level properties of the deframer output stream.
// ----------------------------------------------------------------------------
module fepd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [fepd_pkg::DATA_W-1:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // tlast marks channel records only
  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == fepd_pkg::KIND_CHANNEL)
    else $error("tlast on a non-channel record");

  // event time records always carry the closing layer
  a_time_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fepd_pkg::KIND_EVENT_TIME |->
    m_axis_tdata_o[4:0] == fepd_pkg::LAST_LAYER)
    else $error("event time record with wrong layer");

  a_bad_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fepd_pkg::KIND_BAD_LAYER |->
    m_axis_tdata_o == '0)
    else $error("bad layer record carries data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output record changed");

endmodule

bind front_end_packet_deframer fepd_checker u_fepd_checker (.*);
